// ===== hdl/hbbc_pkg.sv =====
// Shared types, codes and defaults for the hashed block buffer cache.
`timescale 1ns / 1ps
package hbbc_pkg;

  localparam int DEF_ENTRIES = 32;
  localparam int DEF_BUCKETS = 13;
  localparam logic [31:0] STAMP_RESET = 32'd32;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_NO_FREE = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_RDW,
    ST_SCAN,
    ST_DECIDE,
    ST_STEAL,
    ST_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [4:0] result_entry;
    logic       was_hit;
    logic       needs_fill;
    logic       status;
    logic [7:0] reference_count;
  } rsp_t;

endpackage

// ===== hdl/hbbc_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module hbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/hashed_block_buffer_cache_top.sv =====
// Top level of the hashed block buffer cache tag and ownership manager.
`timescale 1ns / 1ps
// This block keeps the tags, reference counts and bucket recency order of a
// pool of ENTRIES disk buffers hashed by block number modulo BUCKETS, and it
// handles one request at a time. A lookup first reduces the block number to
// its home bucket: it multiplies by a reciprocal and then subtracts the
// quotient times BUCKETS. It then makes a single pass over the entry RAM,
// reading one entry per cycle. A decide step picks the outcome. Picking a
// bucket to steal from is skipped on a hit or a free home entry; otherwise the
// other buckets are tried in turn. A last step posts the response. Release,
// pin and unpin go through a read, a read-modify-write and the response. A
// release that drops the count to zero then hashes the stored block number
// and writes the moved entry. An entry index out of range goes straight to
// the response. The request side stalls from acceptance until the response
// is loaded into the output register. A response held by the far side delays
// that load until the hold ends. It blocks only the next response, not the
// work on the next request. Entry state lives in one RAM. A per-entry
// flip-flop marks the entries written since reset, and an unwritten entry
// reads as its reset value, so no clearing pass is needed after reset.
module hashed_block_buffer_cache_top
  import hbbc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  localparam int EW = $clog2(ENTRIES);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = $clog2(ENTRIES + 1);
  // Reciprocal of BUCKETS scaled so the quotient is exact for any 32-bit number.
  localparam int ML = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam logic [32:0] MAGIC =
    33'(((65'd1 << (32 + ML)) + 65'(BUCKETS) - 65'd1) / 65'(BUCKETS));

  typedef struct packed {
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic [7:0]    cnt;
    logic          cv;
    logic [BW-1:0] bkt;
    logic [31:0]   stamp;
  } entry_t;

  state_t state, state_next;

  // Captured request.
  op_t         op;
  logic [7:0]  rdev;
  logic [31:0] rblk;
  logic [EW-1:0] cur_idx;

  // Shared remainder unit.
  logic [31:0]   mreg;
  logic [BW-1:0] mrem;
  logic          mcnt;
  logic [64:0]   mprod;
  logic [31:0]   mquo;
  logic [31:0]   mrem_full;

  // Entry RAM and its read pipeline.
  logic          ram_we;
  logic [EW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata, dv;
  logic [ENTRIES-1:0] ent_init;
  logic          rinit_q, rv_q;
  logic [EW-1:0] ridx_q;

  // Scan results.
  logic [SW-1:0] sc;
  logic          hit_f, hf_f;
  logic [EW-1:0] hit_idx, hf_idx;
  logic [31:0]   hit_stamp, hf_stamp;
  logic [7:0]    hit_cnt;
  logic          hit_cv;
  logic          bfound [BUCKETS];
  logic [EW-1:0] bidx   [BUCKETS];
  logic [31:0]   bstamp [BUCKETS];
  logic [BW-1:0] si, home_plus;

  logic [31:0] stamp_counter;
  entry_t      ent_q;
  rsp_t        pend;

  logic [31:0] idx32;
  logic        idx_bad;
  logic [7:0]  rdw_cnt;
  logic        need_move;
  logic [7:0]  hit_cnt_inc;

  assign idx32   = {27'd0, req.entry_index};
  assign idx_bad = idx32 >= 32'(ENTRIES);
  assign mquo    = 32'(mprod >> (32 + ML));
  assign mrem_full = mreg - mquo * 32'(BUCKETS);
  assign home_plus = (32'(mrem) + 32'd1 >= 32'(BUCKETS)) ? '0 : BW'(32'(mrem) + 32'd1);
  assign hit_cnt_inc = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + 8'd1;

  hbbc_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as its reset contents.
  always_comb begin
    if (rinit_q) begin
      dv = ram_rdata;
    end else begin
      dv = '0;
      dv.stamp = 32'(ridx_q);
    end
  end

  // New count for release, pin and unpin, and whether the entry moves.
  always_comb begin
    rdw_cnt = dv.cnt;
    if (op == OP_PIN) begin
      if (dv.cnt != COUNT_MAX) rdw_cnt = dv.cnt + 8'd1;
    end else if (dv.cnt != 8'd0) begin
      rdw_cnt = dv.cnt - 8'd1;
    end
    need_move = (op == OP_RELEASE) && (dv.cnt == 8'd1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (op_t'(req.operation) == OP_LOOKUP) state_next = ST_MOD;
          else if (idx_bad) state_next = ST_RESP;
          else state_next = ST_RD;
        end
      end
      ST_MOD: if (mcnt) state_next = (op == OP_LOOKUP) ? ST_SCAN : ST_WR;
      ST_RD: state_next = ST_RDW;
      ST_RDW: state_next = need_move ? ST_MOD : ST_RESP;
      ST_SCAN: if (sc == SW'(ENTRIES) && !rv_q) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (hit_f || hf_f) ? ST_RESP : ST_STEAL;
      ST_STEAL: if (si == mrem || bfound[si]) state_next = ST_RESP;
      ST_WR: state_next = ST_RESP;
      ST_RESP: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port control and request side handshake.
  always_comb begin
    req_stall = (state != ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = ent_q;
    ram_raddr = (state == ST_SCAN) ? sc[EW-1:0] : cur_idx;
    unique case (state)
      ST_RDW: begin
        if (!need_move) begin
          ram_we = 1'b1;
          ram_wdata = dv;
          ram_wdata.cnt = rdw_cnt;
        end
      end
      ST_WR: begin
        ram_we = 1'b1;
        ram_wdata = ent_q;
        ram_wdata.bkt = mrem;
        ram_wdata.stamp = stamp_counter;
      end
      ST_DECIDE: begin
        ram_wdata.dev = rdev;
        ram_wdata.blk = rblk;
        ram_wdata.cv  = 1'b1;
        ram_wdata.bkt = mrem;
        if (hit_f) begin
          ram_we = 1'b1;
          ram_waddr = hit_idx;
          ram_wdata.cnt = hit_cnt_inc;
          ram_wdata.stamp = hit_stamp;
        end else begin
          ram_we = hf_f;
          ram_waddr = hf_idx;
          ram_wdata.cnt = 8'd1;
          ram_wdata.stamp = hf_stamp;
        end
      end
      ST_STEAL: begin
        ram_we = (si != mrem) && bfound[si];
        ram_waddr = bidx[si];
        ram_wdata.dev = rdev;
        ram_wdata.blk = rblk;
        ram_wdata.cnt = 8'd1;
        ram_wdata.cv  = 1'b1;
        ram_wdata.bkt = mrem;
        ram_wdata.stamp = stamp_counter;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ent_init <= '0;
      stamp_counter <= STAMP_RESET;
      rsp_valid <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) ent_init[ram_waddr] <= 1'b1;
      rv_q <= (state == ST_SCAN) && (sc < SW'(ENTRIES));
      if ((state == ST_WR) || ((state == ST_STEAL) && (si != mrem) && bfound[si])) begin
        stamp_counter <= stamp_counter + 32'd1;
      end
      if (state == ST_RESP && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rinit_q <= ent_init[ram_raddr];
    ridx_q  <= ram_raddr;
    if (state == ST_RESP && (!rsp_valid || !rsp_stall)) rsp <= pend;
    unique case (state)
      ST_IDLE: begin
        op      <= op_t'(req.operation);
        rdev    <= req.device;
        rblk    <= req.block_number;
        cur_idx <= idx32[EW-1:0];
        mreg    <= req.block_number;
        mrem    <= '0;
        mcnt    <= '0;
        sc      <= '0;
        hit_f   <= 1'b0;
        hf_f    <= 1'b0;
        for (int b = 0; b < BUCKETS; b++) bfound[b] <= 1'b0;
        pend <= {req.entry_index, 1'b0, 1'b0, STATUS_OK, 8'd0};
      end
      ST_MOD: begin
        // The first step registers the quotient product, the second the remainder.
        if (!mcnt) begin
          mprod <= 65'(mreg) * 65'(MAGIC);
        end else begin
          mrem <= mrem_full[BW-1:0];
        end
        mcnt <= ~mcnt;
      end
      ST_RDW: begin
        ent_q <= {dv.dev, dv.blk, rdw_cnt, dv.cv, dv.bkt, dv.stamp};
        mreg <= dv.blk;
        mrem <= '0;
        mcnt <= '0;
        pend.reference_count <= rdw_cnt;
      end
      ST_SCAN: begin
        if (sc < SW'(ENTRIES)) sc <= sc + SW'(1);
        if (rv_q) begin
          if (dv.bkt == mrem && dv.dev == rdev && dv.blk == rblk &&
              (!hit_f || dv.stamp > hit_stamp)) begin
            hit_f <= 1'b1;
            hit_idx <= ridx_q;
            hit_stamp <= dv.stamp;
            hit_cnt <= dv.cnt;
            hit_cv <= dv.cv;
          end
          if (dv.bkt == mrem && dv.cnt == 8'd0 && (!hf_f || dv.stamp < hf_stamp)) begin
            hf_f <= 1'b1;
            hf_idx <= ridx_q;
            hf_stamp <= dv.stamp;
          end
          if (dv.cnt == 8'd0 && 32'(dv.bkt) < 32'(BUCKETS)) begin
            if (!bfound[dv.bkt] || dv.stamp > bstamp[dv.bkt]) begin
              bfound[dv.bkt] <= 1'b1;
              bidx[dv.bkt] <= ridx_q;
              bstamp[dv.bkt] <= dv.stamp;
            end
          end
        end
      end
      ST_DECIDE: begin
        si <= home_plus;
        if (hit_f) begin
          pend.result_entry <= 5'(32'(hit_idx));
          pend.was_hit <= 1'b1;
          pend.needs_fill <= !hit_cv;
          pend.status <= STATUS_OK;
          pend.reference_count <= hit_cnt_inc;
        end else begin
          pend.result_entry <= 5'(32'(hf_idx));
          pend.was_hit <= 1'b0;
          pend.needs_fill <= 1'b1;
          pend.status <= STATUS_OK;
          pend.reference_count <= 8'd1;
        end
      end
      ST_STEAL: begin
        si <= (32'(si) + 32'd1 >= 32'(BUCKETS)) ? '0 : BW'(32'(si) + 32'd1);
        if (si == mrem) begin
          pend <= {5'd0, 1'b0, 1'b0, STATUS_NO_FREE, 8'd0};
        end else begin
          pend.result_entry <= 5'(32'(bidx[si]));
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/hbbc_checker.sv =====
// Port-level checks for the hashed block buffer cache, bound to its top level.
`timescale 1ns / 1ps
module hbbc_checker
  import hbbc_pkg::*;
(
  input logic clk,
  input logic rst,
  input req_t req,
  input logic req_valid,
  input logic req_stall,
  input rsp_t rsp,
  input logic rsp_valid,
  input logic rsp_stall
);

  // A held response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("held response changed");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request side open right after an accepted request");

  // A failed lookup reports nothing but the error.
  a_no_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.result_entry == 5'd0 && !rsp.was_hit &&
      !rsp.needs_fill && rsp.reference_count == 8'd0)
    else $error("error response carries data");

  // A hit always holds a reference.
  a_hit_ref: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.was_hit |-> !rsp.status && rsp.reference_count != 8'd0)
    else $error("hit without a reference");

  // A newly claimed entry starts with one reference.
  a_claim: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.needs_fill && !rsp.was_hit |-> rsp.reference_count == 8'd1)
    else $error("claimed entry count is not one");

endmodule

bind hashed_block_buffer_cache_top hbbc_checker u_hbbc_checker (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);

// ===== sim/hashed_block_buffer_cache_top_tb.sv =====
// Self-checking testbench for the hashed block buffer cache top level.
`timescale 1ns / 1ps
module hashed_block_buffer_cache_top_tb;
  import hbbc_pkg::*;

  localparam int NENT = DEF_ENTRIES;
  localparam int NBKT = DEF_BUCKETS;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  always #6 clk = ~clk;

  hashed_block_buffer_cache_top u_top (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  // Shadow copy of the cache bookkeeping.
  logic [7:0]  sh_dev [NENT];
  logic [31:0] sh_blk [NENT];
  logic [7:0]  sh_cnt [NENT];
  logic        sh_vld [NENT];
  logic [3:0]  sh_bkt [NENT];
  logic [31:0] sh_stamp [NENT];
  logic [31:0] sh_next;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int mismatches = 0;
  int responses_seen = 0;
  int hits_seen = 0, no_free_seen = 0;
  longint cycles = 0;

  function automatic int free_pick(logic [3:0] b, bit want_max);
    int best;
    best = -1;
    for (int e = 0; e < NENT; e++) begin
      if (sh_bkt[e] != b || sh_cnt[e] != 0) continue;
      if (best < 0 || (want_max ? sh_stamp[e] > sh_stamp[best]
                                : sh_stamp[e] < sh_stamp[best])) best = e;
    end
    return best;
  endfunction

  function automatic void bump_recency(int e, logic [3:0] b);
    sh_bkt[e] = b;
    sh_stamp[e] = sh_next;
    sh_next = sh_next + 1;
  endfunction

  // Apply one request to the shadow state and return the response it must produce.
  function automatic rsp_t cache_predict(req_t r);
    rsp_t o;
    logic [3:0] home;
    int found;
    int b;
    o = '0;
    if (op_t'(r.operation) == OP_LOOKUP) begin
      home = 4'(r.block_number % NBKT);
      found = -1;
      for (int e = 0; e < NENT; e++)
        if (sh_bkt[e] == home && sh_dev[e] == r.device && sh_blk[e] == r.block_number &&
            (found < 0 || sh_stamp[e] > sh_stamp[found])) found = e;
      if (found >= 0) begin
        if (sh_cnt[found] != COUNT_MAX) sh_cnt[found]++;
        o.result_entry = 5'(found);
        o.was_hit = 1'b1;
        o.needs_fill = !sh_vld[found];
        o.reference_count = sh_cnt[found];
        sh_vld[found] = 1'b1;
        return o;
      end
      found = free_pick(home, 1'b0);
      if (found < 0) begin
        b = (home + 1) % NBKT;
        while (b != home) begin
          found = free_pick(4'(b), 1'b1);
          if (found >= 0) begin
            bump_recency(found, home);
            break;
          end
          b = (b + 1) % NBKT;
        end
      end
      if (found < 0) begin
        o.status = STATUS_NO_FREE;
        return o;
      end
      sh_dev[found] = r.device;
      sh_blk[found] = r.block_number;
      sh_cnt[found] = 8'd1;
      sh_vld[found] = 1'b1;
      o.result_entry = 5'(found);
      o.needs_fill = 1'b1;
      o.reference_count = 8'd1;
      return o;
    end
    o.result_entry = r.entry_index;
    if (r.entry_index >= NENT) return o;
    if (op_t'(r.operation) == OP_PIN) begin
      if (sh_cnt[r.entry_index] != COUNT_MAX) sh_cnt[r.entry_index]++;
    end else if (sh_cnt[r.entry_index] != 0) begin
      sh_cnt[r.entry_index]--;
      if (op_t'(r.operation) == OP_RELEASE && sh_cnt[r.entry_index] == 0)
        bump_recency(r.entry_index, 4'(sh_blk[r.entry_index] % NBKT));
    end
    o.reference_count = sh_cnt[r.entry_index];
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic req_t make_req(op_t op, logic [7:0] dev, logic [31:0] blk,
                                    logic [4:0] idx);
    req_t r;
    r.operation = op;
    r.device = dev;
    r.block_number = blk;
    r.entry_index = idx;
    return r;
  endfunction

  // Driver: pops the next request, holds it until accepted, then waits a random gap.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      expected_rsps.push_back(cache_predict(req));
      drv_gap = gap_len();
      if (drv_gap == 0 && pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (drv_gap > 0) begin
        drv_gap--;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // Monitor: checks each accepted response and randomizes the stall.
  int stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected response %p", rsp);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("Response %0d: expected %p, got %p",
                                           responses_seen, e, rsp);
          end
          if (e.was_hit) hits_seen++;
          if (e.status == STATUS_NO_FREE) no_free_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        rsp_stall <= (stall_left > 0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Pick an entry index, with a bias toward a small set of randomly chosen indices.
  int handed[$];
  function automatic logic [4:0] pick_idx();
    if (handed.size() > 0 && $urandom_range(0, 9) < 8)
      return 5'(handed[$urandom_range(0, handed.size() - 1)]);
    return 5'($urandom);
  endfunction

  initial begin
    logic [31:0] blk_pool [8];
    logic [7:0] dev;
    logic [31:0] blk;
    int p;
    for (int e = 0; e < NENT; e++) begin
      sh_dev[e] = '0; sh_blk[e] = '0; sh_cnt[e] = '0; sh_vld[e] = 1'b0;
      sh_bkt[e] = '0; sh_stamp[e] = e;
    end
    sh_next = STAMP_RESET;
    for (int i = 0; i < 8; i++) blk_pool[i] = $urandom;
    for (int i = 0; i < 8; i++) handed.push_back($urandom_range(0, NENT - 1));

    // Directed part: field extremes, all operations and the corner cases.
    pending_reqs.push_back(make_req(OP_LOOKUP, 8'h00, 32'h0, 5'd0));      // hit on reset tag
    pending_reqs.push_back(make_req(OP_LOOKUP, 8'hff, 32'hffffffff, 5'd31));
    pending_reqs.push_back(make_req(OP_LOOKUP, 8'hff, 32'hffffffff, 5'd0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 8'h5a, 32'd13, 5'd0));     // free entry in home bucket 0
    pending_reqs.push_back(make_req(OP_RELEASE, 8'hff, 32'hffffffff, 5'd0));
    pending_reqs.push_back(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd0));     // release at zero
    pending_reqs.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 5'd5));       // unpin at zero
    pending_reqs.push_back(make_req(OP_PIN, 8'h00, 32'h0, 5'd31));
    pending_reqs.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 5'd31));
    pending_reqs.push_back(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd1));
    // Pin one entry three times.
    for (int i = 0; i < 3; i++) pending_reqs.push_back(make_req(OP_PIN, 8'h0, 32'h0, 5'd7));
    // Fill every entry with pinned blocks to reach the no-free case.
    for (int i = 0; i < 34; i++)
      pending_reqs.push_back(make_req(OP_LOOKUP, 8'h11, 32'h1000 + i, 5'd0));
    pending_reqs.push_back(make_req(OP_RELEASE, 8'h0, 32'h0, 5'd3));
    pending_reqs.push_back(make_req(OP_LOOKUP, 8'h22, 32'h7, 5'd0));
    for (int e = 0; e < NENT; e++)
      pending_reqs.push_back(make_req(OP_RELEASE, 8'h0, 32'h0, 5'(e)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Random part: lookups lead the mix, drawn from a small block pool so hits, duplicates and
    // steals happen, balanced against releases so entries free up again.
    for (int n = 0; n < 860; n++) begin
      p = $urandom_range(0, 99);
      dev = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      blk = ($urandom_range(0, 4) == 0) ? $urandom : blk_pool[$urandom_range(0, 7)];
      if (p < 45) begin
        pending_reqs.push_back(make_req(OP_LOOKUP, dev, blk, 5'($urandom)));
      end else if (p < 80) begin
        pending_reqs.push_back(make_req(OP_RELEASE, dev, blk, pick_idx()));
      end else if (p < 90) begin
        pending_reqs.push_back(make_req(OP_PIN, dev, blk, pick_idx()));
      end else begin
        pending_reqs.push_back(make_req(OP_UNPIN, dev, blk, pick_idx()));
      end
      if ($urandom_range(0, 3) == 0) handed.push_back($urandom_range(0, NENT - 1));
      if (n % 100 == 99) for (int i = 0; i < 8; i++) blk_pool[i] = $urandom;
    end
    // Sustained pinning of one entry drives the count into saturation.
    for (int i = 0; i < 260; i++)
      pending_reqs.push_back(make_req(OP_PIN, 8'h0, 32'h0, 5'd9));
    pending_reqs.push_back(make_req(OP_LOOKUP, sh_dev[9], sh_blk[9], 5'd0));

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d responses: %0d lookups hit, %0d found no free entry.",
             responses_seen, hits_seen, no_free_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", mismatches,
               expected_rsps.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
